// ===== src/olvd_pkg.sv =====
// ----------------------------------------------------------------------------
// olvd_pkg
// Shared types and constants for the bounded ordered list block.
// ----------------------------------------------------------------------------
`default_nettype none

package olvd_pkg;

  // default number of list entries
  localparam int CAPACITY_DEF = 16;

  // payload widths
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_FRONT  = 2'd0,
    CMD_BACK   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/olvd_in_if.sv =====
// ----------------------------------------------------------------------------
// olvd_in_if
// Command channel: valid/ready handshake with command and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface olvd_in_if;
  logic                               valid;
  logic                               ready;
  olvd_pkg::cmd_t                     cmd;
  logic signed [olvd_pkg::VAL_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ===== src/olvd_out_if.sv =====
// ----------------------------------------------------------------------------
// olvd_out_if
// Result channel: valid/ready handshake with match, reject and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface olvd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       full_reject;
  logic [olvd_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, output found, output full_reject, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input full_reject, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/ordered_list_with_value_delete_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_with_value_delete_top
// Bounded ordered list of 32-bit values held in a circular buffer in RAM,
// with insert front/back, delete first match and search.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-----------------------------------
//  in_ch    | in  | valid/ready         | cmd, value
//  out_ch   | out | valid/ready         | found, full_reject, entry_count
//
//  inserts need no walk: the head moves or the tail is written directly.
//  search/delete walk the list through the single RAM read port, one entry
//  a cycle, comparing each entry as its registered read data returns; the
//  result register is loaded after a match or a miss, once it is free.
//  delete then restarts the read behind a match at position p and moves the
//  n-p-1 entries behind it down, one a cycle, n being the entry count.
//  synchronous active-low reset empties the list; no clearing pass is run.
//  a new item is taken only while idle and the result register is free.
//
`default_nettype none

module ordered_list_with_value_delete_top #(
  parameter int CAPACITY = olvd_pkg::CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  olvd_in_if.sink     in_ch,
  olvd_out_if.source  out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  // list position to RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= CAP_S) s = s - CAP_S;
    return s[AW-1:0];
  endfunction

  state_t                     state_r, state_nxt;
  olvd_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [olvd_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic                       hit_r, hit_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic                       out_reject_r, out_reject_nxt;
  logic [olvd_pkg::CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [olvd_pkg::VAL_W-1:0] ram_wdata;
  logic [olvd_pkg::VAL_W-1:0] ram_rdata;
  logic [AW-1:0]              ram_raddr;
  logic                       out_free;
  logic                       accept;
  logic [CW-1:0]              last_idx;
  logic                       match;

  olvd_ram #(
    .WIDTH (olvd_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake and shared compare
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_idx    = cnt_r - CW'(1);
  assign match       = cmp_vld_r && (ram_rdata == val_r);
  assign ram_raddr   = phys(head_r, rd_idx_r);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.full_reject = out_reject_r;
  assign out_ch.entry_count = out_cnt_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_reject_nxt = out_reject_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, cnt_r);
    ram_wdata      = in_ch.value;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_ch.cmd;
          val_nxt    = in_ch.value;
          rd_idx_nxt = '0;
          hit_nxt    = 1'b0;
          unique case (in_ch.cmd) inside
            olvd_pkg::CMD_FRONT, olvd_pkg::CMD_BACK: begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              if (cnt_r >= CAP_C) begin
                out_reject_nxt = 1'b1;
                out_cnt_nxt    = olvd_pkg::CNT_W'(cnt_r);
              end else begin
                out_reject_nxt = 1'b0;
                out_cnt_nxt    = olvd_pkg::CNT_W'(cnt_r + CW'(1));
                cnt_nxt        = cnt_r + CW'(1);
                ram_we         = 1'b1;
                if (in_ch.cmd == olvd_pkg::CMD_FRONT) begin
                  head_nxt  = (head_r == '0) ? LAST_A : head_r - AW'(1);
                  ram_waddr = head_nxt;
                end
              end
            end
            olvd_pkg::CMD_DELETE, olvd_pkg::CMD_SEARCH: begin
              state_nxt = (cnt_r == '0) ? ST_RESP : ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read a cycle, compare the one issued before
        if (rd_idx_r < cnt_r) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
        end
        if (match) begin
          hit_nxt     = 1'b1;
          cmp_vld_nxt = 1'b0;
          if (cmd_r == olvd_pkg::CMD_SEARCH) begin
            state_nxt = ST_RESP;
          end else if (cmp_idx_r == last_idx) begin
            cnt_nxt   = last_idx;
            state_nxt = ST_RESP;
          end else begin
            rd_idx_nxt = cmp_idx_r + CW'(1);
            state_nxt  = ST_SHIFT;
          end
        end else if (cmp_vld_r && cmp_idx_r == last_idx) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_RESP;
        end
      end

      ST_SHIFT: begin
        // read entry j, write it one place toward the front
        if (rd_idx_r < cnt_r) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
        end
        if (cmp_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, cmp_idx_r - CW'(1));
          ram_wdata = ram_rdata;
          if (cmp_idx_r == last_idx) begin
            cmp_vld_nxt = 1'b0;
            cnt_nxt     = last_idx;
            state_nxt   = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_reject_nxt = 1'b0;
          out_cnt_nxt    = olvd_pkg::CNT_W'(cnt_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    out_found_r  <= out_found_nxt;
    out_reject_r <= out_reject_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // entry count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  // insert into a full list is flagged on the next result
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cnt_r == CAP_C &&
     (in_ch.cmd == olvd_pkg::CMD_FRONT || in_ch.cmd == olvd_pkg::CMD_BACK))
    |=> (out_valid_r && out_reject_r && cnt_r == CAP_C))
    else $error("full insert not rejected");

  // no new item while a search or delete is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("item taken while busy");

  // a rejected insert never reports a match
  a_reject_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reject_r) |-> !out_found_r)
    else $error("reject and found both set");

endmodule

`default_nettype wire

// ===== src/olvd_ram.sv =====
// ----------------------------------------------------------------------------
// olvd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module olvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sim/olvd_checker.sv =====
// ----------------------------------------------------------------------------
// olvd_checker
// Watches the command and result channels of the ordered list block, keeps
// its own copy of the list, predicts the outcome of every accepted command
// and compares each returned result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module olvd_checker (
  input  logic clk,
  input  logic rst_n,
  olvd_in_if   in_ch,
  olvd_out_if  out_ch,
  output int   mismatches,
  output int   pending,
  output int   cmds_seen,
  output int   results_seen,
  output int   rejects_seen,
  output int   hits_seen,
  output int   peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  import olvd_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    logic             found;
    logic             full_reject;
    logic [CNT_W-1:0] entry_count;
  } list_outcome_t;

  // shadow list, front first, and outcomes still owed by the block
  logic [VAL_W-1:0] shadow_list[$];
  list_outcome_t    outcome_q[$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    cmds_seen    = 0;
    results_seen = 0;
    rejects_seen = 0;
    hits_seen    = 0;
    peak_fill    = 0;
  end

  // apply one command to the shadow list and return its outcome
  function automatic list_outcome_t apply_command(cmd_t c, logic [VAL_W-1:0] v);
    list_outcome_t r;
    int            pos;
    r   = '0;
    pos = -1;
    // first match counted from the front
    foreach (shadow_list[i])
      if (pos < 0 && shadow_list[i] == v) pos = i;
    case (c)
      CMD_FRONT: begin
        if (shadow_list.size() >= CAP) r.full_reject = 1'b1;
        else shadow_list.push_front(v);
      end
      CMD_BACK: begin
        if (shadow_list.size() >= CAP) r.full_reject = 1'b1;
        else shadow_list.push_back(v);
      end
      CMD_DELETE: begin
        if (pos >= 0) begin
          r.found = 1'b1;
          shadow_list.delete(pos);
        end
      end
      default: begin
        r.found = (pos >= 0);
      end
    endcase
    r.entry_count = CNT_W'(shadow_list.size());
    if (shadow_list.size() > peak_fill) peak_fill = shadow_list.size();
    return r;
  endfunction

  // accept commands first so a same-edge result still finds its prediction
  always @(posedge clk) begin
    list_outcome_t got;
    list_outcome_t want;
    if (!rst_n) begin
      shadow_list.delete();
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        outcome_q.push_back(apply_command(in_ch.cmd, in_ch.value));
        cmds_seen++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.found, out_ch.full_reject, out_ch.entry_count};
        results_seen++;
        if (got.full_reject) rejects_seen++;
        if (got.found) hits_seen++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result found=%0b reject=%0b count=%0d",
                     $realtime, got.found, got.full_reject, got.entry_count);
        end else begin
          want = outcome_q.pop_front();
          if (got.found != want.found || got.full_reject != want.full_reject ||
              got.entry_count != want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("[%0t] result mismatch: expected found=%0b reject=%0b count=%0d,",
                     $realtime, want.found, want.full_reject, want.entry_count);
              $display(" got found=%0b reject=%0b count=%0d",
                       got.found, got.full_reject, got.entry_count);
            end
          end
        end
      end
      pending <= outcome_q.size();
    end
  end

endmodule

// ===== sim/tb_ordered_list_with_value_delete_top.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_list_with_value_delete_top
// Drives directed and random list commands into the ordered list block with
// random gaps and result stalls; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_ordered_list_with_value_delete_top;
  timeunit 1ns;
  timeprecision 1ps;

  import olvd_pkg::*;

  localparam int RANDOM_CMDS = 600;
  localparam int TAIL_START  = 500;
  localparam int DRAIN_AT    = 300;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic tail_phase;

  int mismatches;
  int pending;
  int cmds_seen;
  int results_seen;
  int rejects_seen;
  int hits_seen;
  int peak_fill;
  int cycles;

  logic [VAL_W-1:0] value_pool[8];

  olvd_in_if  in_ch();
  olvd_out_if out_ch();

  ordered_list_with_value_delete_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  olvd_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .cmds_seen    (cmds_seen),
    .results_seen (results_seen),
    .rejects_seen (rejects_seen),
    .hits_seen    (hits_seen),
    .peak_fill    (peak_fill)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side stalls in random bursts, none in the tail
  initial begin : result_stall
    int span;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (tail_phase || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        span = $urandom_range(1, 40);
      end else begin
        out_ch.ready <= 1'b0;
        span = $urandom_range(1, 19);
      end
      repeat (span - 1) @(posedge clk);
    end
  end

  // present one item and hold it until accepted
  task automatic send_cmd(input cmd_t c, input logic [VAL_W-1:0] v);
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // mostly values likely to be held already, sometimes any pattern
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin : stimulus
    int               i;
    int               r;
    int               span;
    int               mode_left;
    bit               growing;
    cmd_t             c;

    rst_n       <= 1'b0;
    tail_phase  <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_SEARCH;
    in_ch.value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, duplicates, misses
    send_cmd(CMD_SEARCH, 32'h0000_0000);
    send_cmd(CMD_DELETE, 32'h0000_0000);
    send_cmd(CMD_FRONT,  32'h8000_0000);
    send_cmd(CMD_BACK,   32'h7fff_ffff);
    send_cmd(CMD_BACK,   32'h0000_0005);
    send_cmd(CMD_FRONT,  32'h0000_0005);
    send_cmd(CMD_SEARCH, 32'h0000_0005);
    send_cmd(CMD_DELETE, 32'h0000_0005);
    send_cmd(CMD_SEARCH, 32'h0000_0005);
    send_cmd(CMD_DELETE, 32'h0000_3039);
    send_cmd(CMD_DELETE, 32'h7fff_ffff);
    send_cmd(CMD_DELETE, 32'h8000_0000);

    // directed: fill to capacity, then refused inserts
    for (i = 0; i < CAPACITY_DEF - 1; i++)
      send_cmd(i[0] ? CMD_BACK : CMD_FRONT,
               i[1] ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i)));
    send_cmd(CMD_FRONT,  32'hffff_ffff);
    send_cmd(CMD_BACK,   32'h0000_0000);
    send_cmd(CMD_SEARCH, 32'h0000_0001);

    // random: phases that grow or shrink the list over a small value pool
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7fff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;
    growing   = 1'b1;
    mode_left = $urandom_range(20, 60);

    for (i = 0; i < RANDOM_CMDS; i++) begin
      if (i == TAIL_START) tail_phase <= 1'b1;
      if (mode_left == 0) begin
        growing   = !growing;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;

      // hold off once until every result is back
      if (i == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end else if (i < TAIL_START && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        span = $urandom_range(1, 19);
        repeat (span) @(posedge clk);
      end

      r = $urandom_range(0, 99);
      if (growing)
        c = (r < 35) ? CMD_FRONT : (r < 65) ? CMD_BACK : (r < 82) ? CMD_DELETE : CMD_SEARCH;
      else
        c = (r < 12) ? CMD_FRONT : (r < 24) ? CMD_BACK : (r < 75) ? CMD_DELETE : CMD_SEARCH;
      send_cmd(c, pick_value());
    end

    // wait for the last results, then let the block settle
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d commands, checked %0d results: %0d refused inserts, %0d matches",
             cmds_seen, results_seen, rejects_seen, hits_seen);
    $display("list filled up to %0d entries, %0d mismatches", peak_fill, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== ordered_list_with_value_delete_top.f =====
src/olvd_pkg.sv
src/olvd_in_if.sv
src/olvd_out_if.sv
src/olvd_ram.sv
src/ordered_list_with_value_delete_top.sv
sim/olvd_checker.sv
sim/tb_ordered_list_with_value_delete_top.sv
